// ----- rtl/core/iee_pkg.sv -----
// iee_pkg: shared widths and the request/status types of the shared
// arithmetic unit. No dependencies; imported by iee_arith_unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package iee_pkg;

    // working width of the evaluator arithmetic
    localparam int DATA_WIDTH = 32;
    // width of the result port
    localparam int RESULT_W   = 32;
    // iteration counter of the shared unit
    localparam int ITER_W     = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    typedef enum logic [1:0] {
        AOP_MUL = 2'd0,
        AOP_DIV = 2'd1,
        AOP_MOD = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/iee_arith_unit.sv -----
// iee_arith_unit: iterative shift-add multiplier and restoring signed divider
// sharing one adder. Depends on iee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iee_arith_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire iee_pkg::arith_req_t            req,
    input  wire logic [iee_pkg::DATA_WIDTH-1:0] lhs,
    input  wire logic [iee_pkg::DATA_WIDTH-1:0] rhs,
    output iee_pkg::arith_stat_t                stat,
    output logic [iee_pkg::DATA_WIDTH-1:0]      result
);
    import iee_pkg::*;

    typedef enum logic [1:0] {
        AU_IDLE,
        AU_RUN,
        AU_FIX
    } au_state_t;

    au_state_t             state_reg, state_next;
    arith_op_t             op_reg, op_next;
    logic [ITER_W-1:0]     cnt_reg, cnt_next;
    logic [DATA_WIDTH:0]   part_reg, part_next;    // remainder or product
    logic [DATA_WIDTH-1:0] word_reg, word_next;    // quotient or multiplier
    logic [DATA_WIDTH-1:0] oper_reg, oper_next;    // divisor or multiplicand
    logic                  lneg_reg, lneg_next;
    logic                  rneg_reg, rneg_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;
    logic                  done_reg, done_next;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   sum;
    logic [DATA_WIDTH-1:0] rem_w;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        part_next   = part_reg;
        word_next   = word_reg;
        oper_next   = oper_reg;
        lneg_next   = lneg_reg;
        rneg_next   = rneg_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        // the one shared adder: add for multiply, subtract for divide
        shifted = {part_reg[DATA_WIDTH-1:0], word_reg[DATA_WIDTH-1]};
        if (op_reg == AOP_MUL)
        begin
            sum = part_reg + {1'b0, oper_reg};
        end
        else
        begin
            sum = shifted - {1'b0, oper_reg};
        end
        rem_w = part_reg[DATA_WIDTH-1:0];

        unique case (state_reg)
            AU_IDLE:
            begin
                if (req.start)
                begin
                    op_next   = req.op;
                    cnt_next  = '0;
                    part_next = '0;
                    if (req.op == AOP_MUL)
                    begin
                        word_next = rhs;
                        oper_next = lhs;
                        lneg_next = 1'b0;
                        rneg_next = 1'b0;
                    end
                    else
                    begin
                        // magnitudes; the most negative value stays as its unsigned magnitude
                        lneg_next = lhs[DATA_WIDTH-1];
                        rneg_next = rhs[DATA_WIDTH-1];
                        word_next = lhs[DATA_WIDTH-1] ? (~lhs + 1'b1) : lhs;
                        oper_next = rhs[DATA_WIDTH-1] ? (~rhs + 1'b1) : rhs;
                    end
                    state_next = AU_RUN;
                end
            end
            AU_RUN:
            begin
                if (op_reg == AOP_MUL)
                begin
                    if (word_reg[0])
                    begin
                        part_next = sum;
                    end
                    word_next = word_reg >> 1;
                    oper_next = oper_reg << 1;
                end
                else
                begin
                    if (!sum[DATA_WIDTH])
                    begin
                        part_next = sum;
                        word_next = {word_reg[DATA_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        part_next = shifted;
                        word_next = {word_reg[DATA_WIDTH-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(DATA_WIDTH - 1))
                begin
                    state_next = AU_FIX;
                end
            end
            AU_FIX:
            begin
                // sign fix: quotient truncates toward zero, remainder follows dividend
                unique case (op_reg)
                    AOP_MUL: result_next = rem_w;
                    AOP_DIV: result_next = (lneg_reg ^ rneg_reg) ? (~word_reg + 1'b1) : word_reg;
                    AOP_MOD: result_next = lneg_reg ? (~rem_w + 1'b1) : rem_w;
                    default: result_next = rem_w;
                endcase
                done_next  = 1'b1;
                state_next = AU_IDLE;
            end
            default:
            begin
                state_next = AU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= AU_IDLE;
            op_reg     <= AOP_MUL;
            cnt_reg    <= '0;
            part_reg   <= '0;
            word_reg   <= '0;
            oper_reg   <= '0;
            lneg_reg   <= 1'b0;
            rneg_reg   <= 1'b0;
            result_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            cnt_reg    <= cnt_next;
            part_reg   <= part_next;
            word_reg   <= word_next;
            oper_reg   <= oper_next;
            lneg_reg   <= lneg_next;
            rneg_reg   <= rneg_next;
            result_reg <= result_next;
            done_reg   <= done_next;
        end
    end

    assign stat.busy = (state_reg != AU_IDLE);
    assign stat.done = done_reg;
    assign result    = result_reg;

`ifndef SYNTH
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && state_reg == AU_IDLE) |=> (state_reg == AU_RUN))
        else $error("shared unit did not start");

    a_done_from_fix: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == AU_FIX && state_reg == AU_IDLE))
        else $error("done without a fix step");

    a_count_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == AU_FIX) |-> (cnt_reg == ITER_W'(DATA_WIDTH)))
        else $error("iteration count wrong at fix step");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/infix_expression_evaluator_unit.sv -----
// infix_expression_evaluator_unit: character parser, sequencer and result
// register of the left-to-right evaluator. Depends on iee_pkg and iee_arith_unit.
// a digit, space or + - character is applied by the parser alone; a space or
//   operator that closes an operand of * / % holds in_stall while the shared
//   multiply/divide unit iterates one bit a cycle
// throughput: one character per cycle while in_stall is low
// a terminator result is registered in the cycle after the terminator is taken;
//   one that closes a * / % operand passes CS_CALC and CS_EMIT first; the result
//   register lets the next request in while out_stall is low
// reset: rst_n asynchronous, clears all state at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module infix_expression_evaluator_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   character,
    input  wire logic                         end_of_text,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [iee_pkg::RESULT_W-1:0] result_value,
    output logic [1:0]                        error_code
);
    import iee_pkg::*;

    // ascii codes the parser knows
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_STAR  = 8'd42;
    localparam logic [7:0] CHAR_SLASH = 8'd47;
    localparam logic [7:0] CHAR_PCT   = 8'd37;

    typedef enum logic [2:0] {
        PS_WAIT_FIRST,
        PS_FIRST,
        PS_WAIT_OP,
        PS_WAIT_NEXT,
        PS_NEXT,
        PS_ERROR
    } parse_state_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_SYNTAX  = 2'd1,
        ERR_DIVZERO = 2'd2
    } err_t;

    // sequencer: taking characters, waiting on the shared unit, emitting a late result
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_CALC,
        CS_EMIT
    } ctl_state_t;

    function automatic logic signed [RESULT_W-1:0] to_result(input logic [DATA_WIDTH-1:0] v);
        return RESULT_W'(signed'(v));
    endfunction

    ctl_state_t                 ctl_reg, ctl_next;
    parse_state_t               ps_reg, ps_next;
    logic [DATA_WIDTH-1:0]      acc_reg, acc_next;
    logic [DATA_WIDTH-1:0]      opd_reg, opd_next;
    op_t                        pend_reg, pend_next;
    err_t                       err_reg, err_next;
    parse_state_t               resume_ps_reg, resume_ps_next;
    op_t                        resume_op_reg, resume_op_next;
    logic                       final_reg, final_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [RESULT_W-1:0] out_value_reg, out_value_next;
    err_t                       out_code_reg, out_code_next;

    arith_req_t            au_req;
    arith_stat_t           au_stat;
    logic [DATA_WIDTH-1:0] au_result;

    logic                  take;
    logic                  is_digit;
    logic                  is_space;
    logic                  is_op;
    op_t                   char_op;
    logic [DATA_WIDTH-1:0] digit_val;
    logic [DATA_WIDTH-1:0] pushed_acc;
    logic [DATA_WIDTH-1:0] pushed_opd;
    logic                  emit;
    err_t                  emit_err;
    logic [DATA_WIDTH-1:0] emit_val;

    // a request is blocked only while the sequencer is busy or a result cannot drain
    assign in_stall = (ctl_reg != CS_IDLE) || (out_valid_reg && out_stall);
    assign take     = in_valid && !in_stall;

    // character classes
    assign is_digit  = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign is_space  = (character == CHAR_SPACE);
    assign digit_val = DATA_WIDTH'(character[3:0]);

    always_comb
    begin
        is_op   = 1'b1;
        char_op = OP_ADD;
        case (character)
            CHAR_PLUS:  char_op = OP_ADD;
            CHAR_MINUS: char_op = OP_SUB;
            CHAR_STAR:  char_op = OP_MUL;
            CHAR_SLASH: char_op = OP_DIV;
            CHAR_PCT:   char_op = OP_MOD;
            default:    is_op   = 1'b0;
        endcase
    end

    // v * 10 + digit, wrapping at the working width
    assign pushed_acc = (acc_reg << 3) + (acc_reg << 1) + digit_val;
    assign pushed_opd = (opd_reg << 3) + (opd_reg << 1) + digit_val;

    always_comb
    begin
        ctl_next       = ctl_reg;
        ps_next        = ps_reg;
        acc_next       = acc_reg;
        opd_next       = opd_reg;
        pend_next      = pend_reg;
        err_next       = err_reg;
        resume_ps_next = resume_ps_reg;
        resume_op_next = resume_op_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_code_next  = out_code_reg;
        au_req.start   = 1'b0;
        au_req.op      = AOP_MUL;
        emit           = 1'b0;
        emit_err       = ERR_NONE;
        emit_val       = acc_reg;

        // result register drains on its own handshake
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctl_reg)
            CS_IDLE:
            begin
                if (take && end_of_text)
                begin
                    // terminator: close the expression
                    unique case (ps_reg)
                        PS_NEXT:
                        begin
                            if ((pend_reg == OP_DIV || pend_reg == OP_MOD) && opd_reg == '0)
                            begin
                                emit     = 1'b1;
                                emit_err = ERR_DIVZERO;
                            end
                            else if (pend_reg == OP_ADD)
                            begin
                                emit     = 1'b1;
                                emit_val = acc_reg + opd_reg;
                            end
                            else if (pend_reg == OP_SUB)
                            begin
                                emit     = 1'b1;
                                emit_val = acc_reg - opd_reg;
                            end
                            else
                            begin
                                au_req.start = 1'b1;
                                final_next   = 1'b1;
                                ctl_next     = CS_CALC;
                            end
                        end
                        PS_WAIT_NEXT:
                        begin
                            // expression ends right after an operator
                            emit     = 1'b1;
                            emit_err = ERR_SYNTAX;
                        end
                        PS_ERROR:
                        begin
                            emit     = 1'b1;
                            emit_err = (err_reg == ERR_NONE) ? ERR_SYNTAX : err_reg;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
                else if (take)
                begin
                    unique case (ps_reg)
                        PS_WAIT_FIRST:
                        begin
                            if (is_digit)
                            begin
                                acc_next = digit_val;
                                ps_next  = PS_FIRST;
                            end
                            else if (!is_space)
                            begin
                                err_next = ERR_SYNTAX;
                                ps_next  = PS_ERROR;
                            end
                        end
                        PS_FIRST:
                        begin
                            if (is_digit)
                            begin
                                acc_next = pushed_acc;
                            end
                            else if (is_space)
                            begin
                                ps_next = PS_WAIT_OP;
                            end
                            else if (is_op)
                            begin
                                pend_next = char_op;
                                ps_next   = PS_WAIT_NEXT;
                            end
                            else
                            begin
                                err_next = ERR_SYNTAX;
                                ps_next  = PS_ERROR;
                            end
                        end
                        PS_WAIT_OP:
                        begin
                            if (is_op)
                            begin
                                pend_next = char_op;
                                ps_next   = PS_WAIT_NEXT;
                            end
                            else if (!is_space)
                            begin
                                err_next = ERR_SYNTAX;
                                ps_next  = PS_ERROR;
                            end
                        end
                        PS_WAIT_NEXT:
                        begin
                            if (is_digit)
                            begin
                                opd_next = digit_val;
                                ps_next  = PS_NEXT;
                            end
                            else if (!is_space)
                            begin
                                err_next = ERR_SYNTAX;
                                ps_next  = PS_ERROR;
                            end
                        end
                        PS_NEXT:
                        begin
                            if (is_digit)
                            begin
                                opd_next = pushed_opd;
                            end
                            else if (is_space || is_op)
                            begin
                                // operand ends: apply the pending operator
                                resume_ps_next = is_space ? PS_WAIT_OP : PS_WAIT_NEXT;
                                resume_op_next = is_space ? pend_reg : char_op;
                                if ((pend_reg == OP_DIV || pend_reg == OP_MOD) && opd_reg == '0)
                                begin
                                    err_next = ERR_DIVZERO;
                                    ps_next  = PS_ERROR;
                                end
                                else if (pend_reg == OP_ADD || pend_reg == OP_SUB)
                                begin
                                    acc_next  = (pend_reg == OP_ADD) ? (acc_reg + opd_reg)
                                                                     : (acc_reg - opd_reg);
                                    ps_next   = is_space ? PS_WAIT_OP : PS_WAIT_NEXT;
                                    pend_next = is_space ? pend_reg : char_op;
                                end
                                else
                                begin
                                    au_req.start = 1'b1;
                                    final_next   = 1'b0;
                                    ctl_next     = CS_CALC;
                                end
                            end
                            else
                            begin
                                err_next = ERR_SYNTAX;
                                ps_next  = PS_ERROR;
                            end
                        end
                        default:
                        begin
                            // sticky error: ignore everything until the terminator
                            ps_next = PS_ERROR;
                            if (err_reg == ERR_NONE)
                            begin
                                err_next = ERR_SYNTAX;
                            end
                        end
                    endcase
                end

                case (pend_reg)
                    OP_DIV:  au_req.op = AOP_DIV;
                    OP_MOD:  au_req.op = AOP_MOD;
                    default: au_req.op = AOP_MUL;
                endcase
            end
            CS_CALC:
            begin
                if (au_stat.done)
                begin
                    acc_next = au_result;
                    if (final_reg)
                    begin
                        ctl_next = CS_EMIT;
                    end
                    else
                    begin
                        ps_next   = resume_ps_reg;
                        pend_next = resume_op_reg;
                        ctl_next  = CS_IDLE;
                    end
                end
            end
            CS_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    emit     = 1'b1;
                    ctl_next = CS_IDLE;
                end
            end
            default:
            begin
                ctl_next = CS_IDLE;
            end
        endcase

        // load the result register and restart the parser
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_value_next = (emit_err == ERR_NONE) ? to_result(emit_val) : '0;
            out_code_next  = emit_err;
            ps_next        = PS_WAIT_FIRST;
            acc_next       = '0;
            opd_next       = '0;
            pend_next      = OP_ADD;
            err_next       = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= CS_IDLE;
            ps_reg        <= PS_WAIT_FIRST;
            acc_reg       <= '0;
            opd_reg       <= '0;
            pend_reg      <= OP_ADD;
            err_reg       <= ERR_NONE;
            resume_ps_reg <= PS_WAIT_FIRST;
            resume_op_reg <= OP_ADD;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_code_reg  <= ERR_NONE;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            ps_reg        <= ps_next;
            acc_reg       <= acc_next;
            opd_reg       <= opd_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            resume_ps_reg <= resume_ps_next;
            resume_op_reg <= resume_op_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_code_reg  <= out_code_next;
        end
    end

    // shared multiply / divide unit
    iee_arith_unit u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (au_req),
        .lhs    (acc_reg),
        .rhs    (opd_reg),
        .stat   (au_stat),
        .result (au_result)
    );

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign error_code   = out_code_reg;

`ifndef SYNTH
    a_error_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (ps_reg == PS_ERROR) |-> (err_reg != ERR_NONE))
        else $error("error state without an error code");

    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != ERR_NONE) |-> (result_value == '0))
        else $error("error result carries a value");

    a_term_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (take && end_of_text && ps_reg != PS_NEXT) |=> out_valid)
        else $error("terminator gave no result");

    a_calc_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        au_req.start |=> (ctl_reg == CS_CALC && au_stat.busy))
        else $error("unit start without busy sequencer");
`endif

endmodule

`default_nettype wire

// ----- bench/infix_expression_evaluator_unit_test.sv -----
// infix_expression_evaluator_unit_test: self-checking bench for the left-to-right
// expression evaluator; predicts each terminator result and compares it field by field.
// Depends on iee_pkg and the infix_expression_evaluator_unit rtl.
`timescale 1ns / 1ps

module infix_expression_evaluator_unit_test;

    localparam int DW       = iee_pkg::DATA_WIDTH;
    localparam int RESULT_W = iee_pkg::RESULT_W;

    localparam int TARGET_ITEMS   = 800;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef logic [DW-1:0] data_t;

    typedef enum logic [2:0] {
        WAIT_FIRST,
        IN_FIRST,
        WAIT_OPERATOR,
        WAIT_OPERAND,
        IN_OPERAND,
        FAULTED
    } parse_phase_t;

    typedef enum logic [2:0] {
        OPR_ADD,
        OPR_SUB,
        OPR_MUL,
        OPR_DIV,
        OPR_MOD
    } operator_t;

    typedef enum logic [1:0] {
        CODE_OK       = 2'd0,
        CODE_SYNTAX   = 2'd1,
        CODE_DIV_ZERO = 2'd2
    } status_t;

    typedef struct {
        logic signed [RESULT_W-1:0] value;
        logic [1:0]                 code;
    } outcome_t;

    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_PCT   = "%";
    localparam data_t      RADIX    = 10;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [7:0]                   character;
    logic                         end_of_text;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [RESULT_W-1:0]   result_value;
    logic [1:0]                   error_code;

    // evaluator state mirrored by the bench
    parse_phase_t phase;
    data_t        acc;
    data_t        opnd;
    operator_t    pend;
    status_t      err_latch;

    outcome_t     expected_evaluations[$];
    logic [7:0]   line_buf[$];

    int  error_count      = 0;
    int  items_sent       = 0;
    int  idle_cycles      = 0;
    bit  quiet_mode       = 1'b0;
    bit  hold_off_request = 1'b0;
    bit  hold_off_done    = 1'b0;

    infix_expression_evaluator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .character    (character),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .error_code   (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    task automatic clear_evaluator();
        phase     = WAIT_FIRST;
        acc       = '0;
        opnd      = '0;
        pend      = OPR_ADD;
        err_latch = CODE_OK;
    endtask

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic bit decode_operator(input logic [7:0] c, output operator_t op);
        bit found;
        found = 1'b1;
        op    = OPR_ADD;
        case (c)
            CH_PLUS:  op = OPR_ADD;
            CH_MINUS: op = OPR_SUB;
            CH_STAR:  op = OPR_MUL;
            CH_SLASH: op = OPR_DIV;
            CH_PCT:   op = OPR_MOD;
            default:  found = 1'b0;
        endcase
        return found;
    endfunction

    task automatic raise_error(input status_t code);
        if (err_latch == CODE_OK)
            err_latch = code;
        phase = FAULTED;
    endtask

    // folds the operand into the accumulator; 0 on a zero divisor
    function automatic bit apply_pending();
        data_t               a;
        data_t               b;
        logic signed [DW-1:0] sa;
        logic signed [DW-1:0] sb;
        a  = acc;
        b  = opnd;
        sa = a;
        sb = b;
        case (pend)
            OPR_ADD: acc = a + b;
            OPR_SUB: acc = a - b;
            OPR_MUL: acc = a * b;
            default:
            begin
                if (b == '0)
                    return 1'b0;
                // divisor of -1 wraps the most negative quotient
                if (b == '1)
                    acc = (pend == OPR_DIV) ? -a : '0;
                else if (pend == OPR_DIV)
                    acc = sa / sb;
                else
                    acc = sa % sb;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic logic signed [RESULT_W-1:0] to_result(input data_t v);
        logic signed [63:0] wide;
        wide = $signed(v);
        return wide[RESULT_W-1:0];
    endfunction

    task automatic evaluate_char(input logic [7:0] c, input logic eot);
        operator_t op;
        outcome_t  res;
        if (eot)
        begin
            res.value = '0;
            if (phase == IN_OPERAND && !apply_pending())
                raise_error(CODE_DIV_ZERO);
            if (phase == WAIT_OPERAND)
                raise_error(CODE_SYNTAX);
            if (phase == FAULTED)
            begin
                if (err_latch == CODE_OK)
                    err_latch = CODE_SYNTAX;
            end
            else
                res.value = to_result(acc);
            res.code = (phase == FAULTED) ? err_latch : CODE_OK;
            expected_evaluations.push_back(res);
            clear_evaluator();
        end
        else
        begin
            case (phase)
                WAIT_FIRST:
                    if (is_digit(c))
                    begin
                        acc   = data_t'(c - CH_ZERO);
                        phase = IN_FIRST;
                    end
                    else if (c != CH_SPACE)
                        raise_error(CODE_SYNTAX);
                IN_FIRST:
                    if (is_digit(c))
                        acc = acc * RADIX + data_t'(c - CH_ZERO);
                    else if (c == CH_SPACE)
                        phase = WAIT_OPERATOR;
                    else if (decode_operator(c, op))
                    begin
                        pend  = op;
                        phase = WAIT_OPERAND;
                    end
                    else
                        raise_error(CODE_SYNTAX);
                WAIT_OPERATOR:
                    if (c != CH_SPACE)
                    begin
                        if (decode_operator(c, op))
                        begin
                            pend  = op;
                            phase = WAIT_OPERAND;
                        end
                        else
                            raise_error(CODE_SYNTAX);
                    end
                WAIT_OPERAND:
                    if (is_digit(c))
                    begin
                        opnd  = data_t'(c - CH_ZERO);
                        phase = IN_OPERAND;
                    end
                    else if (c != CH_SPACE)
                        raise_error(CODE_SYNTAX);
                IN_OPERAND:
                    if (is_digit(c))
                        opnd = opnd * RADIX + data_t'(c - CH_ZERO);
                    else if (c == CH_SPACE || decode_operator(c, op))
                    begin
                        if (!apply_pending())
                            raise_error(CODE_DIV_ZERO);
                        else if (c == CH_SPACE)
                            phase = WAIT_OPERATOR;
                        else
                        begin
                            pend  = op;
                            phase = WAIT_OPERAND;
                        end
                    end
                    else
                        raise_error(CODE_SYNTAX);
                default:
                begin
                    phase = FAULTED;
                    if (err_latch == CODE_OK)
                        err_latch = CODE_SYNTAX;
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------- traffic

    // mostly no gap, some short ones, a few long ones; none in quiet mode
    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offers one request and waits for it to be taken
    task automatic send_item(input logic [7:0] c, input logic eot);
        int gap;
        in_valid    <= 1'b1;
        character   <= c;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_stall);
        evaluate_char(c, eot);
        items_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid    <= 1'b0;
            character   <= 8'($urandom);
            end_of_text <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_line();
        for (int k = 0; k < line_buf.size(); k++)
            send_item(line_buf[k], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic load_string(input string s);
        line_buf.delete();
        for (int k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
    endtask

    function automatic logic [7:0] operator_char(input int k);
        case (k)
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            default: return CH_PCT;
        endcase
    endfunction

    task automatic add_spaces();
        int n;
        n = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
        repeat (n) line_buf.push_back(CH_SPACE);
    endtask

    // small numbers mostly, plus zero divisors, -1, extremes and wrapping literals
    task automatic add_number();
        int          r;
        logic [31:0] n;
        string       digits;
        r = $urandom_range(0, 99);
        if (r >= 94)
        begin
            repeat ($urandom_range(11, 16))
                line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        else
        begin
            if (r < 55)
                n = $urandom_range(0, 99);
            else if (r < 65)
                n = 0;
            else if (r < 72)
                n = 1;
            else if (r < 77)
                n = 32'hFFFF_FFFF;
            else if (r < 82)
                n = 32'h8000_0000;
            else if (r < 86)
                n = 32'h7FFF_FFFF;
            else
                n = $urandom;
            digits = $sformatf("%0d", n);
            for (int k = 0; k < digits.len(); k++)
                line_buf.push_back(digits[k]);
        end
    endtask

    task automatic build_expression();
        int terms;
        int kind;
        line_buf.delete();
        terms = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
        add_spaces();
        for (int k = 0; k < terms; k++)
        begin
            if (k > 0)
            begin
                add_spaces();
                line_buf.push_back(operator_char($urandom_range(0, 4)));
                add_spaces();
            end
            add_number();
        end
        add_spaces();
        // about a fifth of the lines get broken
        kind = $urandom_range(0, 99);
        if (kind >= 80)
        begin
            case ($urandom_range(0, 3))
                0: line_buf.insert($urandom_range(0, line_buf.size()),
                                   8'($urandom_range(0, 255)));
                1: line_buf.push_back(operator_char($urandom_range(0, 4)));
                2: line_buf.push_front(operator_char($urandom_range(0, 4)));
                default: line_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // ---------------------------------------------------------------- result side

    // random stalls, or one long hold-off when a test asks for it
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_evaluations.size() == 0)
            begin
                $display("%0t: result with none expected, value %0d code %0d",
                         $time, result_value, error_code);
                error_count++;
            end
            else
            begin
                want = expected_evaluations.pop_front();
                if (result_value !== want.value)
                begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, want.value, result_value);
                    error_count++;
                end
                if (error_code !== want.code)
                begin
                    $display("%0t: error_code expected %0d actual %0d",
                             $time, want.code, error_code);
                    error_count++;
                end
            end
        end
    end

    // ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        // empty line, terminator carrying an all-ones character
        send_item(8'hFF, 1'b1);
        // no precedence, operator right after a number
        load_string("12+7*3");
        send_line();
        // negative result, space before operator only
        load_string("8 -9");
        send_line();
        load_string("7/0");
        send_line();
        // line ends right after an operator
        load_string("5%");
        send_line();
        // all-zero character, then the error stays
        send_item(8'h00, 1'b0);
        load_string("1");
        send_line();
        // zero divisor stays latched over later junk
        load_string("9%0 x");
        send_line();
    endtask

    // receiver holds off while requests keep coming, so the unit backs up
    task automatic test_back_pressure();
        quiet_mode       = 1'b1;
        hold_off_request = 1'b1;
        hold_off_done    = 1'b0;
        for (int k = 0; k < 10; k++)
        begin
            load_string((k % 3 == 0) ? "6*7" : "4");
            send_line();
        end
        while (!hold_off_done)
            @(posedge clk);
        // a stretch with no idling on either side
        for (int k = 0; k < 6; k++)
        begin
            build_expression();
            send_line();
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_expressions();
        while (items_sent < TARGET_ITEMS)
        begin
            build_expression();
            send_line();
        end
    endtask

    initial
    begin
        clear_evaluator();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        character   <= 8'h00;
        end_of_text <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_pressure();
        test_random_expressions();

        in_valid <= 1'b0;
        while (expected_evaluations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- infix_expression_evaluator_unit.f -----
rtl/core/iee_pkg.sv
rtl/core/iee_arith_unit.sv
rtl/core/infix_expression_evaluator_unit.sv
bench/infix_expression_evaluator_unit_test.sv
